// ===== design/ordered_list_table_top_macros.svh =====
`ifndef ORDERED_LIST_TABLE_TOP_MACROS_SVH
`define ORDERED_LIST_TABLE_TOP_MACROS_SVH

// Clocked check, held off during reset
`define OLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen
`define OLT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/olt_pkg.sv =====
`timescale 1ns / 1ps

package olt_pkg;

	localparam int OLT_CAPACITY = 128;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int LEN_W        = 8;
	localparam int OP_W         = 3;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_GET,
		OP_PRIOR,
		OP_NEXT,
		OP_CLEAR
	} olt_op_t;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} olt_in_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] value_out;
		logic [LEN_W-1:0]         length_out;
	} olt_out_t;

	// validated operation broadcast to every cell
	typedef struct packed {
		logic                     ins_en;
		logic                     del_en;
		logic                     get_en;
		logic                     prior_en;
		logic                     next_en;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} olt_cmd_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] val;
	} olt_cand_t;

	// lower list index wins
	function automatic olt_cand_t olt_merge(olt_cand_t a, olt_cand_t b);
		return a.hit ? a : b;
	endfunction

endpackage

// ===== design/olt_cell.sv =====
`timescale 1ns / 1ps

module olt_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 8
) (
	input  logic                             clk,
	input  olt_pkg::olt_cmd_t                cmd,
	input  logic [CNT_W-1:0]                 count,
	input  logic signed [olt_pkg::DATA_W-1:0] left_val,
	input  logic signed [olt_pkg::DATA_W-1:0] right_val,
	output logic signed [olt_pkg::DATA_W-1:0] entry,
	output olt_pkg::olt_cand_t               cand
);
	import olt_pkg::*;

	localparam int PW = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [PW-1:0] SELF = PW'(IDX + 1);

	logic signed [DATA_W-1:0] entry_q;
	logic [PW-1:0]            pos_w;
	logic                     match;
	logic                     prior_hit;
	logic                     next_hit;
	logic                     sel_hit;

	assign pos_w = PW'(cmd.position);
	assign match = (entry_q == cmd.value);

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (SELF == pos_w) begin
				entry_q <= cmd.value;
			end else if (SELF > pos_w) begin
				entry_q <= left_val;
			end
		end else if (cmd.del_en && (SELF >= pos_w)) begin
			entry_q <= right_val;
		end
	end

	assign prior_hit = cmd.prior_en && (IDX >= 1) && (count > CNT_W'(IDX)) && match;
	assign next_hit  = cmd.next_en && (count > CNT_W'(IDX + 1)) && match;
	assign sel_hit   = (cmd.get_en || cmd.del_en) && (SELF == pos_w);

	always_comb begin
		cand.hit = prior_hit || next_hit || sel_hit;
		priority if (prior_hit) begin
			cand.val = left_val;
		end else if (next_hit) begin
			cand.val = right_val;
		end else begin
			cand.val = entry_q;
		end
	end

	assign entry = entry_q;

endmodule

// ===== design/olt_tree.sv =====
`timescale 1ns / 1ps

module olt_tree #(
	parameter int N   = 128,
	parameter int LVL = 7
) (
	input  logic               clk,
	input  logic               load,
	input  olt_pkg::olt_cand_t leaf [N],
	output olt_pkg::olt_cand_t root
);
	import olt_pkg::*;

	localparam int NP    = 1 << LVL;
	localparam int NODES = 2 * NP - 1;

	olt_cand_t node_q [NODES];
	olt_cand_t node_d [NODES];

	for (genvar n = 0; n < NP - 1; n++) begin : g_node
		assign node_d[n] = olt_merge(node_q[2*n+1], node_q[2*n+2]);
	end

	for (genvar m = 0; m < NP; m++) begin : g_leaf
		if (m < N) begin : g_used
			assign node_d[NP-1+m] = load ? leaf[m] : node_q[NP-1+m];
		end else begin : g_pad
			assign node_d[NP-1+m] = '0;
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
	end

	assign root = node_q[0];

endmodule

// ===== design/ordered_list_table_top.sv =====
`timescale 1ns / 1ps
// Ordered list of signed 32-bit entries, up to CAPACITY of them.
// Input channel in_valid/in_ready/in_data carries one transaction: op, 1-based
// position and value (insert, delete, get, prior, next, clear).
// Output channel out_valid/out_ready/out_data returns one transaction per input:
// ok, value_out and length_out (entry count after the operation).
// The list lives in a row of cells, one entry each; insert and delete shift the
// cells from the given position on towards their neighbour in the acceptance
// cycle. Every cell offers a candidate result, and a registered priority tree of
// clog2(CAPACITY) levels picks the lowest-indexed one.
// A transaction passes through the leaf registers and the tree levels to the root
// and then into the output register. Only one transaction is in the tree at a
// time; the next transaction is taken in the cycle the result moves to the
// output register.
// Reset empties the list (count 0); entry contents are not cleared.
// A stalled receiver holds the result in the output register; one further
// transaction is processed behind it and then in_ready stays low until the
// output register frees.

`include "ordered_list_table_top_macros.svh"

module ordered_list_table_top #(
	parameter int CAPACITY = olt_pkg::OLT_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  olt_pkg::olt_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output olt_pkg::olt_out_t out_data
);
	import olt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LVL   = $clog2(CAPACITY);
	localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int TW    = $clog2(LVL + 1);

	logic [CNT_W-1:0]  count_q;
	logic              busy_q;
	logic [TW-1:0]     step_q;
	logic              ok_q;
	logic              accept;
	logic              settled;
	logic              finish;
	logic [PW-1:0]     pos_w;
	logic [PW-1:0]     cnt_w;
	logic              pos_in;
	logic              ins_ok;
	logic              del_ok;
	logic              get_ok;
	logic              clr;
	olt_cmd_t          cmd;
	olt_cand_t         cand [CAPACITY];
	olt_cand_t         root;
	olt_cand_t         root_seen;
	logic signed [DATA_W-1:0] ent [CAPACITY];

	assign settled  = busy_q && (step_q == '0);
	assign finish   = settled && (!out_valid || out_ready);
	assign in_ready = !busy_q || finish;
	assign accept   = in_valid && in_ready;

	assign pos_w  = PW'(in_data.position);
	assign cnt_w  = PW'(count_q);
	assign pos_in = (pos_w != '0) && (pos_w <= cnt_w);
	assign ins_ok = (in_data.op == OP_INSERT) && (pos_w != '0)
		&& (PW'(pos_w - 1'b1) <= cnt_w) && (count_q != CNT_W'(CAPACITY));
	assign del_ok = (in_data.op == OP_DELETE) && pos_in;
	assign get_ok = (in_data.op == OP_GET) && pos_in;
	assign clr    = (in_data.op == OP_CLEAR);

	always_comb begin
		cmd.ins_en   = accept && ins_ok;
		cmd.del_en   = accept && del_ok;
		cmd.get_en   = accept && get_ok;
		cmd.prior_en = accept && (in_data.op == OP_PRIOR);
		cmd.next_en  = accept && (in_data.op == OP_NEXT);
		cmd.position = in_data.position;
		cmd.value    = in_data.value;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		olt_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.left_val  ((i == 0) ? ent[i] : ent[(i == 0) ? 0 : i - 1]),
			.right_val ((i == CAPACITY - 1) ? ent[i] : ent[(i == CAPACITY - 1) ? i : i + 1]),
			.entry     (ent[i]),
			.cand      (cand[i])
		);
	end

	olt_tree #(
		.N   (CAPACITY),
		.LVL (LVL)
	) u_tree (
		.clk  (clk),
		.load (accept),
		.leaf (cand),
		.root (root)
	);

	// value of a missed search is don't-care in the tree; zero it here
	assign root_seen = root.hit ? root : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			busy_q    <= 1'b0;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				priority if (clr) begin
					count_q <= '0;
				end else if (ins_ok) begin
					count_q <= count_q + 1'b1;
				end else if (del_ok) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= TW'(LVL);
			end else begin
				if (finish) begin
					busy_q <= 1'b0;
				end
				if (busy_q && (step_q != '0)) begin
					step_q <= step_q - 1'b1;
				end
			end
			if (finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q <= ins_ok || clr;
		end
		if (finish) begin
			out_data.ok         <= ok_q || root_seen.hit;
			out_data.value_out  <= root_seen.val;
			out_data.length_out <= LEN_W'(count_q);
		end
	end

	`OLT_NEVER(a_count_max, count_q > CNT_W'(CAPACITY), "entry count above capacity")
	`OLT_ASSERT(a_ins_grow, accept && ins_ok |=> count_q == $past(count_q) + 1'b1, "insert lost")
	`OLT_ASSERT(a_start, accept |=> busy_q && step_q == TW'(LVL), "transaction start not tracked")
	`OLT_ASSERT(a_root_hold, settled && !accept |=> $stable(root_seen), "result moved while held")

endmodule

// ===== test/tb_ordered_list_table_top.sv =====
`timescale 1ns / 1ps

module tb_ordered_list_table_top;
	import olt_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
	localparam int ITEMS       = 1650;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 24;
	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIXED  = 2;
	localparam int MODE_SEARCH = 3;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	class olt_table_model;
		logic signed [DATA_W-1:0] slots [OLT_CAPACITY];
		int fill;
		int peak;
		int full_refused;
		int checked;
		int faults;
		olt_out_t awaited [$];

		function new();
			fill = 0;
			peak = 0;
			full_refused = 0;
			checked = 0;
			faults = 0;
		endfunction

		function void report(string what);
			$display("ERROR @%0t: %s", $time, what);
			faults++;
		endfunction

		// work out the result of an accepted transaction and queue it
		function void note_input(olt_in_t t);
			olt_out_t r;
			int p;
			int k;
			r = '0;
			p = int'(t.position);
			case (t.op)
				OP_INSERT: begin
					if (fill == OLT_CAPACITY)
						full_refused++;
					if (p >= 1 && p <= fill + 1 && fill < OLT_CAPACITY) begin
						for (k = fill; k > p - 1; k--)
							slots[k] = slots[k - 1];
						slots[p - 1] = t.value;
						fill++;
						r.ok = 1'b1;
					end
				end
				OP_DELETE: begin
					if (p >= 1 && p <= fill) begin
						r.value_out = slots[p - 1];
						for (k = p - 1; k + 1 < fill; k++)
							slots[k] = slots[k + 1];
						fill--;
						r.ok = 1'b1;
					end
				end
				OP_GET: begin
					if (p >= 1 && p <= fill) begin
						r.value_out = slots[p - 1];
						r.ok = 1'b1;
					end
				end
				OP_PRIOR: begin
					for (k = 1; k < fill && !r.ok; k++) begin
						if (slots[k] == t.value) begin
							r.value_out = slots[k - 1];
							r.ok = 1'b1;
						end
					end
				end
				OP_NEXT: begin
					for (k = 0; k + 1 < fill && !r.ok; k++) begin
						if (slots[k] == t.value) begin
							r.value_out = slots[k + 1];
							r.ok = 1'b1;
						end
					end
				end
				OP_CLEAR: begin
					fill = 0;
					r.ok = 1'b1;
				end
				default: ;
			endcase
			if (fill > peak)
				peak = fill;
			r.length_out = LEN_W'(fill);
			awaited.push_back(r);
		endfunction

		function void check_result(olt_out_t got);
			olt_out_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result with nothing outstanding: %p", got));
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.ok !== want.ok)
				report($sformatf("ok %b, expected %b", got.ok, want.ok));
			if (got.value_out !== want.value_out)
				report($sformatf("value_out %0d, expected %0d", got.value_out,
					want.value_out));
			if (got.length_out !== want.length_out)
				report($sformatf("length_out %0d, expected %0d", got.length_out,
					want.length_out));
		endfunction
	endclass

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	olt_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	olt_out_t out_data;

	olt_table_model model;
	int  cycle_count = 0;
	int  sent = 0;
	bit  calm = 1'b0;

	ordered_list_table_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			model.check_result(out_data);
		out_ready <= calm || ($urandom_range(99) >= 34);
	end

	task automatic push_item(input logic [OP_W-1:0] op, input int pos,
		input logic signed [DATA_W-1:0] val);
		olt_in_t t;
		t.op = op;
		t.position = POS_W'(pos);
		t.value = val;
		if (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 34);
		end
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		model.note_input(t);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (model.awaited.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] rand_value();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return DATA_W'($urandom_range(7)) - 4;
		if (r < 55) begin
			case ($urandom_range(3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return -1;
				default: return 0;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic signed [DATA_W-1:0] search_value();
		if (model.fill > 0 && $urandom_range(99) < 75)
			return model.slots[$urandom_range(model.fill - 1)];
		return rand_value();
	endfunction

	function automatic int entry_pos(input int span);
		if (span > 0 && $urandom_range(99) < 90)
			return $urandom_range(span, 1);
		return $urandom_range(129);
	endfunction

	task automatic random_item(input int mode);
		int r;
		int ins_t, del_t, get_t, pri_t, nxt_t, clr_t;
		r = $urandom_range(99);
		case (mode)
			MODE_GROW:   begin ins_t = 70; del_t = 80; get_t = 88; pri_t = 93; nxt_t = 98; clr_t = 99; end
			MODE_SHRINK: begin ins_t = 20; del_t = 65; get_t = 80; pri_t = 87; nxt_t = 94; clr_t = 97; end
			MODE_SEARCH: begin ins_t = 30; del_t = 38; get_t = 50; pri_t = 73; nxt_t = 96; clr_t = 97; end
			default:     begin ins_t = 35; del_t = 60; get_t = 75; pri_t = 85; nxt_t = 95; clr_t = 97; end
		endcase
		calm = (sent >= 700 && sent < 1000);
		if (r < ins_t)
			push_item(OP_INSERT, entry_pos(model.fill + 1), rand_value());
		else if (r < del_t)
			push_item(OP_DELETE, entry_pos(model.fill), rand_value());
		else if (r < get_t)
			push_item(OP_GET, entry_pos(model.fill), rand_value());
		else if (r < pri_t)
			push_item(OP_PRIOR, $urandom_range(129), search_value());
		else if (r < nxt_t)
			push_item(OP_NEXT, $urandom_range(129), search_value());
		else if (r < clr_t)
			push_item(OP_CLEAR, $urandom_range(129), rand_value());
		else
			push_item($urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7,
				$urandom_range(129), rand_value());
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("ERROR: timeout after %0d cycles, %0d results outstanding",
			cycle_count, model.awaited.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int mode;
		int span;
		model = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		push_item(OP_GET, 1, 0);
		push_item(OP_DELETE, 1, 0);
		push_item(OP_PRIOR, 0, 0);
		push_item(OP_NEXT, 0, 0);
		push_item(OP_INSERT, 0, 5);
		push_item(OP_INSERT, 2, 5);
		// build [0, MAX, MIN, MAX, -1]
		push_item(OP_INSERT, 1, VAL_MIN);
		push_item(OP_INSERT, 2, VAL_MAX);
		push_item(OP_INSERT, 1, 0);
		push_item(OP_INSERT, 4, -1);
		push_item(OP_INSERT, 2, VAL_MAX);
		push_item(OP_GET, 5, 0);
		push_item(OP_GET, 6, 0);
		push_item(OP_GET, 129, 0);
		// match only at head / tail, duplicate match
		push_item(OP_PRIOR, 0, 0);
		push_item(OP_PRIOR, 0, VAL_MAX);
		push_item(OP_NEXT, 0, -1);
		push_item(OP_NEXT, 128, VAL_MAX);
		push_item(OP_NEXT, 0, 12345);
		push_item(OP_DELETE, 6, 0);
		push_item(OP_DELETE, 2, 0);
		push_item(OP_DELETE, 4, 0);
		push_item(OP_UNUSED_6, 1, 7);
		push_item(OP_UNUSED_7, 255, -1);
		push_item(OP_CLEAR, 0, 0);
		drain();

		// fill to capacity, then inserts into a full list
		while (model.fill < OLT_CAPACITY)
			push_item(OP_INSERT, $urandom_range(model.fill + 1, 1), rand_value());
		push_item(OP_INSERT, 129, 1);
		push_item(OP_INSERT, 1, 1);
		push_item(OP_INSERT, OLT_CAPACITY, 1);
		push_item(OP_GET, OLT_CAPACITY, 0);
		push_item(OP_GET, OLT_CAPACITY + 1, 0);
		push_item(OP_DELETE, OLT_CAPACITY, 0);
		drain();

		while (sent < ITEMS) begin
			mode = $urandom_range(MODE_SEARCH);
			span = $urandom_range(120, 10);
			repeat (span)
				random_item(mode);
			if ($urandom_range(3) == 0)
				drain();
		end
		calm = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (model.awaited.size() != 0)
			model.report($sformatf("%0d results never arrived", model.awaited.size()));
		$display("covered %0d transactions, %0d results checked, list up to %0d of %0d",
			sent, model.checked, model.peak, OLT_CAPACITY);
		$display("inserts into a full list: %0d", model.full_refused);
		if (model.faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== ordered_list_table_top.f =====
+incdir+design
design/olt_pkg.sv
design/olt_cell.sv
design/olt_tree.sv
design/ordered_list_table_top.sv
test/tb_ordered_list_table_top.sv
